// ===== src/czsm_pkg.sv =====
// ----------------------------------------------------------------------------
// czsm_pkg
// Shared constants and types of the calorimeter zero-suppression block.
// ----------------------------------------------------------------------------
package czsm_pkg;

  // List store geometry.
  localparam int MAX_CELLS = 32768;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int FILL_W    = ADDR_W + 1;
  localparam int MAX_DIM   = 32;

  // Field widths.
  localparam int E_W      = 32;
  localparam int IDX_W    = 5;
  localparam int DIM_W    = 6;
  localparam int TOTAL_W  = 47;
  localparam int WSUM_W   = 52;
  localparam int COUNT_W  = 16;
  localparam int MEAN_W   = 13;
  localparam int SPREAD_W = 16;
  localparam int ENTRY_W  = E_W + 2 * IDX_W;

  // Divider geometry: dividend covers the spread sums, divisor at most 256 * total.
  localparam int DIVD_W = 76;
  localparam int DIVS_W = 56;
  localparam int QUO_W  = 16;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  // Configuration register indexes.
  localparam logic [7:0] REG_THRESHOLD = 8'd0;
  localparam logic [7:0] REG_RHO       = 8'd1;
  localparam logic [7:0] REG_PHI       = 8'd2;
  localparam logic [7:0] REG_Z         = 8'd3;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/calorimeter_zero_suppress_moments.sv =====
// ----------------------------------------------------------------------------
// calorimeter_zero_suppress_moments
// Zero suppression of calorimeter cells with energy-weighted shower moments.
// ----------------------------------------------------------------------------
// Usage: one cell energy per input beat, in scan order phi, rho, layer, over a
// cylinder sized by the cfg_ registers (index 0 threshold, 1 rho, 2 phi, 3 z).
// A cell above threshold produces a cell-entry beat on the output in the cycle
// after acceptance; the input takes a new beat only once the output register
// is empty, so suppressed cells are taken one per cycle while it stays empty.
// The last cell of the scan starts the event close: two divisions for the
// means, one pipelined pass over the kept-cell list (one entry per cycle,
// then the pipeline drains), then two more divisions for the spreads.
// A division runs 16 quotient steps, none for a zero divisor or an overflow.
// The summary beat (last = 1) is presented once the spread divisions are
// done and the output register is free; no input is taken meanwhile.
// Reset (synchronous, active low) clears the scan and the sums and restores
// the register defaults; the list store needs no clearing since only entries
// written in the current event are read. When the receiver stalls, the output
// beat holds and the input channel waits.
// ----------------------------------------------------------------------------
module calorimeter_zero_suppress_moments (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [czsm_pkg::E_W-1:0]        in_cell_energy_ev,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [czsm_pkg::E_W-1:0]        out_energy_ev,
  output logic [czsm_pkg::IDX_W-1:0]      out_rho_index,
  output logic [czsm_pkg::IDX_W-1:0]      out_phi_index,
  output logic [czsm_pkg::IDX_W-1:0]      out_layer_index,
  output logic [czsm_pkg::TOTAL_W-1:0]    out_total_energy_ev,
  output logic [czsm_pkg::COUNT_W-1:0]    out_kept_count,
  output logic [czsm_pkg::MEAN_W-1:0]     out_long_mean,
  output logic [czsm_pkg::MEAN_W-1:0]     out_radial_mean,
  output logic [czsm_pkg::SPREAD_W-1:0]   out_long_spread,
  output logic [czsm_pkg::SPREAD_W-1:0]   out_radial_spread,
  output logic                            out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIVL  = 3'd1;
  localparam logic [2:0] ST_DIVR  = 3'd2;
  localparam logic [2:0] ST_PASS  = 3'd3;
  localparam logic [2:0] ST_DIVSL = 3'd4;
  localparam logic [2:0] ST_DIVSR = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam int PROD_W = czsm_pkg::E_W + czsm_pkg::IDX_W;
  localparam int SQ_W   = 2 * czsm_pkg::MEAN_W;
  localparam int PSQ_W  = czsm_pkg::E_W + SQ_W;

  logic [2:0] state_r;

  // Configuration registers.
  logic [31:0]                  thr_r;
  logic [czsm_pkg::DIM_W-1:0]   rho_cells_r, phi_cells_r, z_cells_r;

  // Event state.
  logic [czsm_pkg::IDX_W-1:0]   scan_phi_r, scan_rho_r, scan_layer_r;
  logic [czsm_pkg::TOTAL_W-1:0] total_r;
  logic [czsm_pkg::WSUM_W-1:0]  wl_r, wr_r;
  logic [czsm_pkg::COUNT_W-1:0] kept_r;
  logic [czsm_pkg::FILL_W-1:0]  fill_r;
  logic [czsm_pkg::MEAN_W-1:0]  lm_r, rm_r;
  logic [czsm_pkg::SPREAD_W-1:0] sl_q_r, sr_q_r;
  logic [czsm_pkg::DIVD_W-1:0]  sl_r, sr_r;
  logic                         div_start_r;

  // Output register.
  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [czsm_pkg::E_W-1:0]        out_e_r;
  logic [czsm_pkg::IDX_W-1:0]      out_rho_r, out_phi_r, out_layer_r;
  logic [czsm_pkg::TOTAL_W-1:0]    out_total_r;
  logic [czsm_pkg::COUNT_W-1:0]    out_kept_r;
  logic [czsm_pkg::MEAN_W-1:0]     out_lm_r, out_rm_r;
  logic [czsm_pkg::SPREAD_W-1:0]   out_ls_r, out_rs_r;

  // Second-pass pipeline.
  logic [czsm_pkg::FILL_W-1:0]  rd_i_r;
  logic                         v1_r, v2_r, v3_r;
  logic [SQ_W-1:0]              sql_r, sqr_r;
  logic [czsm_pkg::E_W-1:0]     e2_r;
  logic [PSQ_W-1:0]             pl_r, pr_r;

  logic                         in_acc, kept, last_cell, issue, out_free, emit_now;
  logic [czsm_pkg::DIM_W-1:0]   nr, np, nz;
  logic                         wrap_z, wrap_r, wrap_p;
  logic [czsm_pkg::TOTAL_W:0]   tot_sum;
  logic [PROD_W-1:0]            prod_l, prod_r;
  logic [czsm_pkg::WSUM_W:0]    wl_sum, wr_sum;
  logic [czsm_pkg::ENTRY_W-1:0] rdata;
  logic [czsm_pkg::IDX_W-1:0]   rd_layer, rd_rho;
  logic [czsm_pkg::MEAN_W-1:0]  pos_l, pos_r, dl, dr;
  logic [czsm_pkg::MEAN_W-1:0]  q_mean;
  czsm_pkg::div_req_t           div_req;
  czsm_pkg::div_rsp_t           div_rsp;

  function automatic logic [czsm_pkg::DIM_W-1:0] eff_dim(input logic [czsm_pkg::DIM_W-1:0] r);
    if (r == '0) begin
      return czsm_pkg::DIM_W'(1);
    end else if (r > czsm_pkg::DIM_W'(czsm_pkg::MAX_DIM)) begin
      return czsm_pkg::DIM_W'(czsm_pkg::MAX_DIM);
    end
    return r;
  endfunction

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_now  = (state_r == ST_EMIT) && out_free;

  // Scan position and wrap decisions.
  assign nr        = eff_dim(rho_cells_r);
  assign np        = eff_dim(phi_cells_r);
  assign nz        = eff_dim(z_cells_r);
  assign wrap_z    = ({1'b0, scan_layer_r} + 1'b1) >= nz;
  assign wrap_r    = ({1'b0, scan_rho_r} + 1'b1) >= nr;
  assign wrap_p    = ({1'b0, scan_phi_r} + 1'b1) >= np;
  assign last_cell = wrap_z && wrap_r && wrap_p;
  assign kept      = in_cell_energy_ev > thr_r;

  // Saturating accumulations of one cell.
  assign tot_sum = {1'b0, total_r} + (czsm_pkg::TOTAL_W + 1)'(in_cell_energy_ev);
  assign prod_l  = in_cell_energy_ev * scan_layer_r;
  assign prod_r  = in_cell_energy_ev * scan_rho_r;
  assign wl_sum  = {1'b0, wl_r} + (czsm_pkg::WSUM_W + 1)'(prod_l);
  assign wr_sum  = {1'b0, wr_r} + (czsm_pkg::WSUM_W + 1)'(prod_r);

  // Divider operands follow the close-of-event step.
  always_comb begin
    div_req.start    = div_start_r;
    div_req.dividend = '0;
    div_req.divisor  = czsm_pkg::DIVS_W'(total_r);
    unique case (state_r)
      ST_DIVL: div_req.dividend = czsm_pkg::DIVD_W'({wl_r, 8'd0});
      ST_DIVR: div_req.dividend = czsm_pkg::DIVD_W'({wr_r, 8'd0});
      ST_DIVSL: begin
        div_req.dividend = sl_r;
        div_req.divisor  = czsm_pkg::DIVS_W'({total_r, 8'd0});
      end
      ST_DIVSR: begin
        div_req.dividend = sr_r;
        div_req.divisor  = czsm_pkg::DIVS_W'({total_r, 8'd0});
      end
      default: div_req.dividend = '0;
    endcase
  end

  assign q_mean = (div_rsp.quotient > czsm_pkg::QUO_W'(czsm_pkg::MEAN_MAX)) ?
                  czsm_pkg::MEAN_MAX : div_rsp.quotient[czsm_pkg::MEAN_W-1:0];

  czsm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Kept-cell list: written on acceptance, read during the second pass.
  assign issue = (state_r == ST_PASS) && (rd_i_r < fill_r);

  czsm_list_mem u_mem (
    .clk   (clk),
    .we    (in_acc && kept && fill_r < czsm_pkg::FILL_W'(czsm_pkg::MAX_CELLS)),
    .waddr (fill_r[czsm_pkg::ADDR_W-1:0]),
    .wdata ({in_cell_energy_ev, scan_rho_r, scan_layer_r}),
    .raddr (rd_i_r[czsm_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign rd_layer = rdata[czsm_pkg::IDX_W-1:0];
  assign rd_rho   = rdata[2*czsm_pkg::IDX_W-1:czsm_pkg::IDX_W];
  assign pos_l    = {rd_layer, 8'd0};
  assign pos_r    = {rd_rho, 8'd0};
  assign dl       = (pos_l >= lm_r) ? pos_l - lm_r : lm_r - pos_l;
  assign dr       = (pos_r >= rm_r) ? pos_r - rm_r : rm_r - pos_r;

  // Second-pass pipeline: squares, weighted products, then accumulation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    sql_r <= dl * dl;
    sqr_r <= dr * dr;
    e2_r  <= rdata[czsm_pkg::ENTRY_W-1:2*czsm_pkg::IDX_W];
    pl_r  <= e2_r * sql_r;
    pr_r  <= e2_r * sqr_r;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 32'd500;
      rho_cells_r <= czsm_pkg::DIM_W'(25);
      phi_cells_r <= czsm_pkg::DIM_W'(25);
      z_cells_r   <= czsm_pkg::DIM_W'(25);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        czsm_pkg::REG_THRESHOLD: thr_r       <= cfg_data;
        czsm_pkg::REG_RHO:       rho_cells_r <= cfg_data[czsm_pkg::DIM_W-1:0];
        czsm_pkg::REG_PHI:       phi_cells_r <= cfg_data[czsm_pkg::DIM_W-1:0];
        czsm_pkg::REG_Z:         z_cells_r   <= cfg_data[czsm_pkg::DIM_W-1:0];
        default:                 thr_r       <= thr_r;
      endcase
    end
  end

  // Event sequencer and sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      div_start_r  <= 1'b0;
      scan_phi_r   <= '0;
      scan_rho_r   <= '0;
      scan_layer_r <= '0;
      total_r      <= '0;
      wl_r         <= '0;
      wr_r         <= '0;
      kept_r       <= '0;
      fill_r       <= '0;
      rd_i_r       <= '0;
      sl_r         <= '0;
      sr_r         <= '0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            total_r <= tot_sum[czsm_pkg::TOTAL_W] ? '1 : tot_sum[czsm_pkg::TOTAL_W-1:0];
            if (kept) begin
              if (fill_r < czsm_pkg::FILL_W'(czsm_pkg::MAX_CELLS)) begin
                fill_r <= fill_r + 1'b1;
              end
              if (kept_r != '1) begin
                kept_r <= kept_r + 1'b1;
              end
              wl_r <= wl_sum[czsm_pkg::WSUM_W] ? '1 : wl_sum[czsm_pkg::WSUM_W-1:0];
              wr_r <= wr_sum[czsm_pkg::WSUM_W] ? '1 : wr_sum[czsm_pkg::WSUM_W-1:0];
            end
            if (last_cell) begin
              state_r     <= ST_DIVL;
              div_start_r <= 1'b1;
            end else if (!wrap_z) begin
              scan_layer_r <= scan_layer_r + 1'b1;
            end else begin
              scan_layer_r <= '0;
              if (!wrap_r) begin
                scan_rho_r <= scan_rho_r + 1'b1;
              end else begin
                scan_rho_r <= '0;
                scan_phi_r <= scan_phi_r + 1'b1;
              end
            end
          end
        end
        ST_DIVL: begin
          if (div_rsp.done) begin
            state_r     <= ST_DIVR;
            div_start_r <= 1'b1;
          end
        end
        ST_DIVR: begin
          if (div_rsp.done) begin
            state_r <= ST_PASS;
            rd_i_r  <= '0;
            sl_r    <= '0;
            sr_r    <= '0;
          end
        end
        ST_PASS: begin
          if (issue) begin
            rd_i_r <= rd_i_r + 1'b1;
          end
          if (v3_r) begin
            sl_r <= sl_r + czsm_pkg::DIVD_W'(pl_r);
            sr_r <= sr_r + czsm_pkg::DIVD_W'(pr_r);
          end
          if (!issue && !v1_r && !v2_r && !v3_r) begin
            state_r     <= ST_DIVSL;
            div_start_r <= 1'b1;
          end
        end
        ST_DIVSL: begin
          if (div_rsp.done) begin
            state_r     <= ST_DIVSR;
            div_start_r <= 1'b1;
          end
        end
        ST_DIVSR: begin
          if (div_rsp.done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_now) begin
            state_r      <= ST_IDLE;
            scan_phi_r   <= '0;
            scan_rho_r   <= '0;
            scan_layer_r <= '0;
            total_r      <= '0;
            wl_r         <= '0;
            wr_r         <= '0;
            kept_r       <= '0;
            fill_r       <= '0;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Division results.
  always_ff @(posedge clk) begin
    if (div_rsp.done) begin
      unique case (state_r)
        ST_DIVL:  lm_r   <= q_mean;
        ST_DIVR:  rm_r   <= q_mean;
        ST_DIVSL: sl_q_r <= div_rsp.quotient;
        ST_DIVSR: sr_q_r <= div_rsp.quotient;
        default:  lm_r   <= lm_r;
      endcase
    end
  end

  // Output register: cell entries on acceptance, the summary at event close.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && kept) || emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && kept) begin
      out_kind_r  <= 1'b0;
      out_e_r     <= in_cell_energy_ev;
      out_rho_r   <= scan_rho_r;
      out_phi_r   <= scan_phi_r;
      out_layer_r <= scan_layer_r;
      out_total_r <= '0;
      out_kept_r  <= '0;
      out_lm_r    <= '0;
      out_rm_r    <= '0;
      out_ls_r    <= '0;
      out_rs_r    <= '0;
    end else if (emit_now) begin
      out_kind_r  <= 1'b1;
      out_e_r     <= '0;
      out_rho_r   <= '0;
      out_phi_r   <= '0;
      out_layer_r <= '0;
      out_total_r <= total_r;
      out_kept_r  <= kept_r;
      out_lm_r    <= lm_r;
      out_rm_r    <= rm_r;
      out_ls_r    <= sl_q_r;
      out_rs_r    <= sr_q_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_energy_ev       = out_e_r;
  assign out_rho_index       = out_rho_r;
  assign out_phi_index       = out_phi_r;
  assign out_layer_index     = out_layer_r;
  assign out_total_energy_ev = out_total_r;
  assign out_kept_count      = out_kept_r;
  assign out_long_mean       = out_lm_r;
  assign out_radial_mean     = out_rm_r;
  assign out_long_spread     = out_ls_r;
  assign out_radial_spread   = out_rs_r;
  assign out_last            = out_kind_r;

  // The list fill never passes the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= czsm_pkg::FILL_W'(czsm_pkg::MAX_CELLS))
    else $error("list fill beyond store depth");

  // A division completes only while the sequencer waits for one.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVL || state_r == ST_DIVR ||
                      state_r == ST_DIVSL || state_r == ST_DIVSR))
    else $error("division result with no waiting step");

  // The second pass reads only entries written in this event.
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> rd_i_r < fill_r)
    else $error("second pass read past the list fill");

  // After the summary goes out the event state is clear.
  a_event_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_now |=> (kept_r == '0 && fill_r == '0 && total_r == '0))
    else $error("event state not cleared after summary");

endmodule

// ===== src/czsm_list_mem.sv =====
// ----------------------------------------------------------------------------
// czsm_list_mem
// Compact list of kept cells: one write port, one registered read port.
// ----------------------------------------------------------------------------
module czsm_list_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [czsm_pkg::ADDR_W-1:0]   waddr,
  input  logic [czsm_pkg::ENTRY_W-1:0]  wdata,
  input  logic [czsm_pkg::ADDR_W-1:0]   raddr,
  output logic [czsm_pkg::ENTRY_W-1:0]  rdata
);

  logic [czsm_pkg::ENTRY_W-1:0] mem [czsm_pkg::MAX_CELLS];
  logic [czsm_pkg::ENTRY_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/czsm_divider.sv =====
// ----------------------------------------------------------------------------
// czsm_divider
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
module czsm_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  czsm_pkg::div_req_t req,
  output czsm_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(czsm_pkg::QUO_W);

  logic                        busy_r;
  logic                        done_r;
  logic [czsm_pkg::DIVD_W-1:0] rem_r;
  logic [czsm_pkg::DIVD_W-1:0] dsh_r;
  logic [czsm_pkg::QUO_W-1:0]  q_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [czsm_pkg::DIVD_W-1:0] top_div;
  logic                        ge;

  // Divisor aligned to the first quotient bit beyond range.
  assign top_div = czsm_pkg::DIVD_W'({req.divisor, {czsm_pkg::QUO_W{1'b0}}});
  assign ge      = rem_r >= dsh_r;

  // Control: start, busy flag and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.divisor == '0 || req.dividend >= top_div) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: trial subtraction of the shifted divisor.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsh_r <= top_div >> 1;
      cnt_r <= CNT_W'(czsm_pkg::QUO_W - 1);
      if (req.divisor == '0) begin
        q_r <= '0;
      end else begin
        q_r <= '1;
      end
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[czsm_pkg::QUO_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// ===== bench/tb_calorimeter_zero_suppress_moments.sv =====
// ----------------------------------------------------------------------------
// tb_calorimeter_zero_suppress_moments
// Self-checking bench for the zero-suppression and shower-moment block.
// ----------------------------------------------------------------------------
// A short table of directed cells and register writes is walked first. A few
// of its rows carry a hand-typed expected beat; all others, and the random
// phases after them, are checked against a behavioural predictor of the scan,
// the kept-cell list and the event-end moments. Both channels idle at random,
// and the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calorimeter_zero_suppress_moments;

  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned CELL_TARGET = 1400;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam logic [7:0] REG_UNUSED   = 8'hFF;
  localparam logic [czsm_pkg::TOTAL_W-1:0] TOTAL_TOP = '1;
  localparam logic [czsm_pkg::WSUM_W-1:0]  WSUM_TOP  = '1;

  typedef struct {
    bit                           kind;
    bit [czsm_pkg::E_W-1:0]       energy;
    bit [czsm_pkg::IDX_W-1:0]     rho;
    bit [czsm_pkg::IDX_W-1:0]     phi;
    bit [czsm_pkg::IDX_W-1:0]     layer;
    bit [czsm_pkg::TOTAL_W-1:0]   total;
    bit [czsm_pkg::COUNT_W-1:0]   count;
    bit [czsm_pkg::MEAN_W-1:0]    lmean;
    bit [czsm_pkg::MEAN_W-1:0]    rmean;
    bit [czsm_pkg::SPREAD_W-1:0]  lspread;
    bit [czsm_pkg::SPREAD_W-1:0]  rspread;
    bit                           last;
  } beat_t;

  typedef struct {
    bit        is_cfg;
    bit [7:0]  index;
    bit [31:0] value;
    bit        typed;
    beat_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [czsm_pkg::E_W-1:0] in_cell_energy_ev = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [czsm_pkg::E_W-1:0] out_energy_ev;
  logic [czsm_pkg::IDX_W-1:0] out_rho_index, out_phi_index, out_layer_index;
  logic [czsm_pkg::TOTAL_W-1:0] out_total_energy_ev;
  logic [czsm_pkg::COUNT_W-1:0] out_kept_count;
  logic [czsm_pkg::MEAN_W-1:0] out_long_mean, out_radial_mean;
  logic [czsm_pkg::SPREAD_W-1:0] out_long_spread, out_radial_spread;
  logic out_last;

  calorimeter_zero_suppress_moments dut (.*);

  // Predictor state: registers, scan position, running sums and kept list.
  bit [31:0] thr_ev;
  bit [5:0]  rho_reg, phi_reg, z_reg;
  int unsigned scan_p, scan_r, scan_l;
  bit [63:0] sum_energy, sum_layer_w, sum_rho_w;
  int unsigned kept_n;
  bit [31:0] kept_e[$];
  bit [4:0]  kept_r[$], kept_l[$];

  beat_t expected_beats[$];
  int unsigned errors = 0;
  int unsigned cells_taken = 0;
  int unsigned cycles = 0;

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned dim_in_use(bit [5:0] r);
    if (r == 0) return 1;
    if (r > czsm_pkg::MAX_DIM) return czsm_pkg::MAX_DIM;
    return r;
  endfunction

  function automatic bit [czsm_pkg::MEAN_W-1:0] weighted_mean(bit [63:0] wsum, bit [63:0] tot);
    bit [63:0] q;
    if (tot == 0) return '0;
    q = (wsum * 256) / tot;
    return (q > 8191) ? czsm_pkg::MEAN_MAX : q[czsm_pkg::MEAN_W-1:0];
  endfunction

  function automatic bit [czsm_pkg::SPREAD_W-1:0] spread_of(bit [127:0] s, bit [63:0] tot);
    bit [127:0] q;
    if (tot == 0) return '0;
    q = s / (128'(tot) * 256);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic reset_event();
    scan_p = 0; scan_r = 0; scan_l = 0;
    sum_energy = 0; sum_layer_w = 0; sum_rho_w = 0;
    kept_n = 0;
    kept_e.delete(); kept_r.delete(); kept_l.delete();
  endtask

  task automatic apply_cfg(bit [7:0] idx, bit [31:0] v);
    case (idx)
      czsm_pkg::REG_THRESHOLD: thr_ev = v;
      czsm_pkg::REG_RHO:       rho_reg = v[5:0];
      czsm_pkg::REG_PHI:       phi_reg = v[5:0];
      czsm_pkg::REG_Z:         z_reg = v[5:0];
      default: ;
    endcase
  endtask

  // Work out the beats that one accepted cell causes and queue them.
  task automatic predict_cell(bit [31:0] e);
    int unsigned nr, np, nz, i;
    bit wz, wr, wp;
    beat_t b;
    bit [czsm_pkg::MEAN_W-1:0] lm, rm;
    bit [127:0] sl, sr;
    int dl, dr;
    nr = dim_in_use(rho_reg);
    np = dim_in_use(phi_reg);
    nz = dim_in_use(z_reg);
    sum_energy = (sum_energy + e > TOTAL_TOP) ? TOTAL_TOP : sum_energy + e;
    if (e > thr_ev) begin
      b = '{default: 0};
      b.energy = e;
      b.rho = scan_r[4:0];
      b.phi = scan_p[4:0];
      b.layer = scan_l[4:0];
      expected_beats.push_back(b);
      if (kept_e.size() < czsm_pkg::MAX_CELLS) begin
        kept_e.push_back(e);
        kept_r.push_back(scan_r[4:0]);
        kept_l.push_back(scan_l[4:0]);
      end
      if (kept_n < 65535) kept_n++;
      sum_layer_w += 64'(e) * (scan_l & 7'h7F);
      if (sum_layer_w > WSUM_TOP) sum_layer_w = WSUM_TOP;
      sum_rho_w += 64'(e) * (scan_r & 7'h7F);
      if (sum_rho_w > WSUM_TOP) sum_rho_w = WSUM_TOP;
    end
    wz = (scan_l + 1 >= nz);
    wr = (scan_r + 1 >= nr);
    wp = (scan_p + 1 >= np);
    if (wz && wr && wp) begin
      // Event close: means first, then spreads about the truncated means.
      lm = weighted_mean(sum_layer_w, sum_energy);
      rm = weighted_mean(sum_rho_w, sum_energy);
      sl = 0;
      sr = 0;
      for (i = 0; i < kept_e.size(); i++) begin
        dl = int'(kept_l[i]) * 256 - int'(lm);
        dr = int'(kept_r[i]) * 256 - int'(rm);
        if (dl < 0) dl = -dl;
        if (dr < 0) dr = -dr;
        sl += 128'(kept_e[i]) * 128'(dl * dl);
        sr += 128'(kept_e[i]) * 128'(dr * dr);
      end
      b = '{default: 0};
      b.kind = 1'b1;
      b.total = sum_energy[czsm_pkg::TOTAL_W-1:0];
      b.count = kept_n[15:0];
      b.lmean = lm;
      b.rmean = rm;
      b.lspread = spread_of(sl, sum_energy);
      b.rspread = spread_of(sr, sum_energy);
      b.last = 1'b1;
      expected_beats.push_back(b);
      reset_event();
    end else if (!wz) begin
      scan_l++;
    end else begin
      scan_l = 0;
      if (!wr) begin
        scan_r++;
      end else begin
        scan_r = 0;
        scan_p++;
      end
    end
  endtask

  // Sender gap: mostly none, sometimes short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one cell and hold it until the block takes it.
  task automatic send_cell(bit [31:0] e, bit typed, beat_t want);
    int unsigned before_n, g;
    in_valid <= 1'b1;
    in_cell_energy_ev <= e;
    do @(posedge clk); while (!in_ready);
    cells_taken++;
    before_n = expected_beats.size();
    predict_cell(e);
    if (typed) begin
      while (expected_beats.size() > before_n) void'(expected_beats.pop_back());
      expected_beats.push_back(want);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Registers change only once every expected beat is out and the close is done.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(bit [7:0] idx, bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t cell_row(bit [31:0] e);
    return '{1'b0, 8'd0, e, 1'b0, '{default: 0}};
  endfunction

  function automatic row_t cfg_row(bit [7:0] idx, bit [31:0] v);
    return '{1'b1, idx, v, 1'b0, '{default: 0}};
  endfunction

  function automatic row_t typed_row(bit [31:0] e, beat_t want);
    return '{1'b0, 8'd0, e, 1'b1, want};
  endfunction

  function automatic bit [31:0] random_dim();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'd0;
      1: return 32'd32;
      2: return 32'd63;
      3: return ($urandom & 32'hFFFF_FFC0) | $urandom_range(1, 4);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic bit [31:0] random_energy();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return thr_ev;
      3: return thr_ev + 1;
      4, 5: return $urandom;
      default: return thr_ev + $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // Receiver: random ready with one long hold-off once the stream is going.
  int unsigned hold_left = 0;
  bit long_done = 1'b0;
  int unsigned rcv_pick;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_done && cells_taken >= 700) begin
      long_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      rcv_pick = $urandom_range(0, 99);
      if (rcv_pick < 60) begin
        out_ready <= 1'b1;
      end else if (rcv_pick < 93) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(10, 40);
      end
    end
  end

  task automatic check_field(string name, bit [63:0] want, bit [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Each output beat against the oldest expectation.
  beat_t head;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual kind %0b", $time,
                 out_kind);
        errors++;
      end else begin
        head = expected_beats.pop_front();
        check_field("kind", head.kind, out_kind);
        check_field("energy_ev", head.energy, out_energy_ev);
        check_field("rho_index", head.rho, out_rho_index);
        check_field("phi_index", head.phi, out_phi_index);
        check_field("layer_index", head.layer, out_layer_index);
        check_field("total_energy_ev", head.total, out_total_energy_ev);
        check_field("kept_count", head.count, out_kept_count);
        check_field("long_mean", head.lmean, out_long_mean);
        check_field("radial_mean", head.rmean, out_radial_mean);
        check_field("long_spread", head.lspread, out_long_spread);
        check_field("radial_spread", head.rspread, out_radial_spread);
        check_field("last", head.last, out_last);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus.
  row_t table_rows[$];
  initial begin
    int unsigned ri, n, prod, phase;
    bit [31:0] dz, dr, dp;
    thr_ev = 500;
    rho_reg = 25;
    phi_reg = 25;
    z_reg = 25;
    reset_event();

    // Directed: threshold edges at reset, single-cell events, a zero total,
    // out-of-range sizes, an unknown index and a size change mid-event.
    table_rows.push_back(cell_row(32'd0));
    table_rows.push_back(cell_row(32'd500));
    table_rows.push_back(typed_row(32'd501, '{0, 501, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0}));
    table_rows.push_back(typed_row(32'hFFFF_FFFF,
                                   '{0, 32'hFFFF_FFFF, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0}));
    table_rows.push_back(cfg_row(czsm_pkg::REG_THRESHOLD, 32'd0));
    table_rows.push_back(cfg_row(czsm_pkg::REG_RHO, 32'd1));
    table_rows.push_back(cfg_row(czsm_pkg::REG_PHI, 32'd1));
    table_rows.push_back(cfg_row(czsm_pkg::REG_Z, 32'd1));
    table_rows.push_back(cell_row(32'd0));
    table_rows.push_back(typed_row(32'd0, '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}));
    table_rows.push_back(cell_row(32'hFFFF_FFFF));
    table_rows.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
    table_rows.push_back(cfg_row(czsm_pkg::REG_THRESHOLD, 32'hFFFF_FFFF));
    table_rows.push_back(cfg_row(czsm_pkg::REG_PHI, 32'hFFFF_FFC0));
    table_rows.push_back(cfg_row(czsm_pkg::REG_RHO, 32'd0));
    table_rows.push_back(cfg_row(czsm_pkg::REG_Z, 32'd2));
    table_rows.push_back(cell_row(32'hFFFF_FFFF));
    table_rows.push_back(cell_row(32'h8000_0000));
    table_rows.push_back(cfg_row(czsm_pkg::REG_THRESHOLD, 32'h7FFF_FFFF));
    table_rows.push_back(cfg_row(czsm_pkg::REG_Z, 32'd3));
    table_rows.push_back(cfg_row(czsm_pkg::REG_RHO, 32'd2));
    table_rows.push_back(cell_row(32'h8000_0000));
    table_rows.push_back(cell_row(32'd0));
    table_rows.push_back(cell_row(32'hFFFF_FFFF));
    table_rows.push_back(cell_row(32'h7FFF_FFFF));
    table_rows.push_back(cell_row(32'd1));
    table_rows.push_back(cell_row(32'h8000_0001));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (ri = 0; ri < table_rows.size(); ri++) begin
      if (table_rows[ri].is_cfg) begin
        wait_idle();
        write_reg(table_rows[ri].index, table_rows[ri].value);
      end else begin
        send_cell(table_rows[ri].value, table_rows[ri].typed, table_rows[ri].want);
      end
    end

    // Random phases: fresh settings, then whole events where they are small.
    phase = 0;
    while (cells_taken < CELL_TARGET) begin
      wait_idle();
      if (phase % 7 == 3) begin
        dz = 32'd32; dr = 32'd1; dp = 32'd1;
      end else if (phase % 11 == 5) begin
        dz = 32'd1; dr = 32'd32; dp = 32'd1;
      end else begin
        dz = random_dim(); dr = random_dim(); dp = random_dim();
      end
      case ($urandom_range(0, 5))
        0: write_reg(czsm_pkg::REG_THRESHOLD, 32'd0);
        1: write_reg(czsm_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
        2: write_reg(czsm_pkg::REG_THRESHOLD, $urandom);
        default: write_reg(czsm_pkg::REG_THRESHOLD, $urandom_range(0, 5000));
      endcase
      write_reg(czsm_pkg::REG_Z, dz);
      write_reg(czsm_pkg::REG_RHO, dr);
      write_reg(czsm_pkg::REG_PHI, dp);
      if ($urandom_range(0, 9) == 0) write_reg(8'($urandom_range(4, 255)), $urandom);
      prod = dim_in_use(z_reg) * dim_in_use(rho_reg) * dim_in_use(phi_reg);
      n = prod * $urandom_range(1, 3);
      if (n > 150) n = $urandom_range(20, 80);
      repeat (n) send_cell(random_energy(), 1'b0, '{default: 0});
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/czsm_pkg.sv
src/czsm_list_mem.sv
src/czsm_divider.sv
src/calorimeter_zero_suppress_moments.sv
bench/tb_calorimeter_zero_suppress_moments.sv
